// File: rtl/core/mandelbrot_escape_pixel_defines.svh
// Assertion macros for the Mandelbrot escape-time pixel block.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef MANDELBROT_ESCAPE_PIXEL_DEFINES_SVH
`define MANDELBROT_ESCAPE_PIXEL_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MEP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MEP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/mep_pkg.sv
// Shared constants and types for the Mandelbrot escape-time pixel block.
// No dependencies; imported by the interfaces and all modules.
package mep_pkg;

  localparam int COORD_WIDTH       = 32;
  localparam int FRAC_BITS         = COORD_WIDTH - 4;
  localparam int COUNT_WIDTH_DEF   = 16;
  localparam int INDEX_WIDTH_DEF   = 12;
  localparam int APB_DATA_WIDTH    = 32;
  localparam int REG_IDX_WIDTH     = 3;
  localparam int APB_ADDR_WIDTH    = REG_IDX_WIDTH + 2;
  localparam int ITER_LIMIT_RST    = 256;

  localparam logic [REG_IDX_WIDTH-1:0] REG_LEFT_EDGE       = 3'd0;
  localparam logic [REG_IDX_WIDTH-1:0] REG_BOTTOM_EDGE     = 3'd1;
  localparam logic [REG_IDX_WIDTH-1:0] REG_COLUMN_STEP     = 3'd2;
  localparam logic [REG_IDX_WIDTH-1:0] REG_ROW_STEP        = 3'd3;
  localparam logic [REG_IDX_WIDTH-1:0] REG_ITERATION_LIMIT = 3'd4;

  // Reset coordinates: -2.0, -1.0 and 2^-10 in Q4.28.
  localparam logic [COORD_WIDTH-1:0] LEFT_EDGE_RST   = 32'hE000_0000;
  localparam logic [COORD_WIDTH-1:0] BOTTOM_EDGE_RST = 32'hF000_0000;
  localparam logic [COORD_WIDTH-1:0] STEP_RST        = 32'h0004_0000;

  localparam logic [7:0] RED_HIGH = 8'd240;

  typedef struct packed {
    logic scale;     // register column*column_step and row*row_step
    logic origin;    // form c, clear z and the count
    logic square;    // register x*x, y*y, x*y
    logic step;      // advance z and the count
    logic load_out;  // move the result into the output register
  } dp_cmd_t;

  typedef struct packed {
    logic done;      // escaped or iteration limit reached
  } dp_status_t;

endpackage

// File: rtl/core/mep_pixel_if.sv
// Pixel word channel: valid/ready handshake carrying column and row.
// Depends on mep_pkg.
interface mep_pixel_if import mep_pkg::*; #(
  parameter int INDEX_WIDTH = INDEX_WIDTH_DEF
);
  logic                   valid;
  logic                   ready;
  logic [INDEX_WIDTH-1:0] column;
  logic [INDEX_WIDTH-1:0] row;

  modport source (output valid, output column, output row, input ready);
  modport sink   (input valid, input column, input row, output ready);
endinterface

// File: rtl/core/mep_result_if.sv
// Result word channel: valid/ready handshake carrying count, flag and color.
// Depends on mep_pkg.
interface mep_result_if import mep_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
);
  logic                   valid;
  logic                   ready;
  logic [COUNT_WIDTH-1:0] escape_count;
  logic                   in_set;
  logic [7:0]             red;
  logic [7:0]             green;
  logic [7:0]             blue;

  modport source (output valid, output escape_count, output in_set, output red,
                  output green, output blue, input ready);
  modport sink   (input valid, input escape_count, input in_set, input red,
                  input green, input blue, output ready);
endinterface

// File: rtl/core/mep_regs.sv
// APB configuration registers: view window, pixel steps and iteration limit.
// Depends on mep_pkg.
module mep_regs import mep_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [APB_ADDR_WIDTH-1:0]     paddr_i,
  input  logic [APB_DATA_WIDTH-1:0]     pwdata_i,
  output logic [APB_DATA_WIDTH-1:0]     prdata_o,
  output logic                          pready_o,
  output logic signed [COORD_WIDTH-1:0] left_edge_o,
  output logic signed [COORD_WIDTH-1:0] bottom_edge_o,
  output logic signed [COORD_WIDTH-1:0] column_step_o,
  output logic signed [COORD_WIDTH-1:0] row_step_o,
  output logic [COUNT_WIDTH-1:0]        iteration_limit_o
);

  logic [COORD_WIDTH-1:0]   left_edge_q, bottom_edge_q, column_step_q, row_step_q;
  logic [COUNT_WIDTH-1:0]   limit_q;
  logic [REG_IDX_WIDTH-1:0] reg_idx;
  logic                     wr_en;

  assign reg_idx  = paddr_i[APB_ADDR_WIDTH-1:2];
  assign wr_en    = psel_i && penable_i && pwrite_i;
  assign pready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_edge_q   <= LEFT_EDGE_RST;
      bottom_edge_q <= BOTTOM_EDGE_RST;
      column_step_q <= STEP_RST;
      row_step_q    <= STEP_RST;
      limit_q       <= COUNT_WIDTH'(ITER_LIMIT_RST);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_LEFT_EDGE:       left_edge_q   <= pwdata_i[COORD_WIDTH-1:0];
        REG_BOTTOM_EDGE:     bottom_edge_q <= pwdata_i[COORD_WIDTH-1:0];
        REG_COLUMN_STEP:     column_step_q <= pwdata_i[COORD_WIDTH-1:0];
        REG_ROW_STEP:        row_step_q    <= pwdata_i[COORD_WIDTH-1:0];
        REG_ITERATION_LIMIT: limit_q       <= pwdata_i[COUNT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LEFT_EDGE:       prdata_o = left_edge_q;
      REG_BOTTOM_EDGE:     prdata_o = bottom_edge_q;
      REG_COLUMN_STEP:     prdata_o = column_step_q;
      REG_ROW_STEP:        prdata_o = row_step_q;
      REG_ITERATION_LIMIT: prdata_o = APB_DATA_WIDTH'(limit_q);
      default:             prdata_o = '0;
    endcase
  end

  assign left_edge_o       = left_edge_q;
  assign bottom_edge_o     = bottom_edge_q;
  assign column_step_o     = column_step_q;
  assign row_step_o        = row_step_q;
  assign iteration_limit_o = limit_q;

endmodule

// File: rtl/core/mep_datapath.sv
// Escape-time datapath: point mapping, z = z^2 + c iteration, color map and
// the result register. Driven by mep_ctrl through dp_cmd_t; depends on mep_pkg.
module mep_datapath import mep_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
  parameter int INDEX_WIDTH = INDEX_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  dp_cmd_t                       cmd_i,
  input  logic [INDEX_WIDTH-1:0]        column_i,
  input  logic [INDEX_WIDTH-1:0]        row_i,
  input  logic signed [COORD_WIDTH-1:0] left_edge_i,
  input  logic signed [COORD_WIDTH-1:0] bottom_edge_i,
  input  logic signed [COORD_WIDTH-1:0] column_step_i,
  input  logic signed [COORD_WIDTH-1:0] row_step_i,
  input  logic [COUNT_WIDTH-1:0]        iteration_limit_i,
  output dp_status_t                    status_o,
  output logic [COUNT_WIDTH-1:0]        escape_count_o,
  output logic                          in_set_o,
  output logic [7:0]                    red_o,
  output logic [7:0]                    green_o,
  output logic [7:0]                    blue_o
);

  localparam int PROD_W = COORD_WIDTH + INDEX_WIDTH + 1;
  localparam int SAT_W  = PROD_W + 1;
  localparam int SQ_W   = 2 * COORD_WIDTH;
  localparam int EXT_W  = SAT_W - COORD_WIDTH;
  // Escape bound 4.0 at the squares' scale of 2*FRAC_BITS fraction bits.
  localparam logic [SQ_W:0] ESC_BOUND =
    {{(SQ_W - 2 * FRAC_BITS - 2){1'b0}}, 1'b1, {(2 * FRAC_BITS + 2){1'b0}}};

  logic signed [PROD_W-1:0]      col_prod_q, row_prod_q, col_prod_d, row_prod_d;
  logic signed [COORD_WIDTH-1:0] c_re_q, c_im_q, x_q, y_q;
  logic signed [SQ_W-1:0]        xx_q, yy_q, xy_q, xx_d, yy_d, xy_d;
  logic [COUNT_WIDTH-1:0]        count_q;
  logic signed [SAT_W-1:0]       c_re_sum, c_im_sum, nx_sum, ny_sum;
  logic signed [SQ_W:0]          diff, diff_sh;
  logic signed [SQ_W-1:0]        xy_sh;
  logic [SQ_W:0]                 mag;
  logic                          escaped, at_limit;
  logic [7:0]                    shade;
  logic [COUNT_WIDTH-1:0]        res_count_q;
  logic                          res_in_set_q;
  logic [7:0]                    res_red_q, res_green_q, res_blue_q;

  function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
    input logic signed [SAT_W-1:0] v
  );
    logic signed [COORD_WIDTH-1:0] r;
    if (v[SAT_W-1:COORD_WIDTH-1] == '0 || v[SAT_W-1:COORD_WIDTH-1] == '1) begin
      r = v[COORD_WIDTH-1:0];
    end else if (v[SAT_W-1]) begin
      r = {1'b1, {(COORD_WIDTH - 1){1'b0}}};
    end else begin
      r = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
    end
    return r;
  endfunction

  assign col_prod_d = $signed({1'b0, column_i}) * column_step_i;
  assign row_prod_d = $signed({1'b0, row_i}) * row_step_i;

  assign c_re_sum = {{EXT_W{left_edge_i[COORD_WIDTH-1]}}, left_edge_i}
                  + {col_prod_q[PROD_W-1], col_prod_q};
  assign c_im_sum = {{EXT_W{bottom_edge_i[COORD_WIDTH-1]}}, bottom_edge_i}
                  + {row_prod_q[PROD_W-1], row_prod_q};

  assign xx_d = x_q * x_q;
  assign yy_d = y_q * y_q;
  assign xy_d = x_q * y_q;

  // Floor division by a power of two is an arithmetic shift; the shifted
  // values fit in a few bits above the coordinate width.
  assign diff    = {xx_q[SQ_W-1], xx_q} - {yy_q[SQ_W-1], yy_q};
  assign diff_sh = diff >>> FRAC_BITS;
  assign xy_sh   = xy_q >>> (FRAC_BITS - 1);
  assign nx_sum  = diff_sh[SAT_W-1:0] + {{EXT_W{c_re_q[COORD_WIDTH-1]}}, c_re_q};
  assign ny_sum  = xy_sh[SAT_W-1:0] + {{EXT_W{c_im_q[COORD_WIDTH-1]}}, c_im_q};

  // The squares of the current z double as the escape test of the last step.
  assign mag      = {1'b0, xx_q} + {1'b0, yy_q};
  assign escaped  = (mag >= ESC_BOUND);
  assign at_limit = (count_q == iteration_limit_i);
  assign status_o.done = escaped || at_limit;
  assign shade    = {count_q[3:0], 4'b0000};

  always_ff @(posedge clk_i) begin
    if (cmd_i.scale) begin
      col_prod_q <= col_prod_d;
      row_prod_q <= row_prod_d;
    end
    if (cmd_i.origin) begin
      c_re_q  <= sat_coord(c_re_sum);
      c_im_q  <= sat_coord(c_im_sum);
      x_q     <= '0;
      y_q     <= '0;
      count_q <= '0;
    end else if (cmd_i.step) begin
      x_q     <= sat_coord(nx_sum);
      y_q     <= sat_coord(ny_sum);
      count_q <= count_q + 1'b1;
    end
    if (cmd_i.square) begin
      xx_q <= xx_d;
      yy_q <= yy_d;
      xy_q <= xy_d;
    end
    if (cmd_i.load_out) begin
      res_count_q  <= count_q;
      res_in_set_q <= at_limit;
      if (at_limit) begin
        res_red_q   <= '0;
        res_green_q <= '0;
        res_blue_q  <= '0;
      end else if (count_q[4]) begin
        res_red_q   <= RED_HIGH;
        res_green_q <= shade;
        res_blue_q  <= shade;
      end else begin
        res_red_q   <= shade;
        res_green_q <= '0;
        res_blue_q  <= '0;
      end
    end
  end

  assign escape_count_o = res_count_q;
  assign in_set_o       = res_in_set_q;
  assign red_o          = res_red_q;
  assign green_o        = res_green_q;
  assign blue_o         = res_blue_q;

endmodule

// File: rtl/core/mep_ctrl.sv
// Controller: sequences point mapping, the square/update loop and hand-off of
// the result word. Issues dp_cmd_t to mep_datapath; depends on mep_pkg.
module mep_ctrl import mep_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ORIGIN = 3'd1;
  localparam logic [2:0] S_SQUARE = 3'd2;
  localparam logic [2:0] S_UPDATE = 3'd3;
  localparam logic [2:0] S_HOLD   = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  // The output register can take a new word when empty or being drained.
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.scale = 1'b1;
          state_d     = S_ORIGIN;
        end
      end
      S_ORIGIN: begin
        cmd_o.origin = 1'b1;
        state_d      = S_SQUARE;
      end
      S_SQUARE: begin
        cmd_o.square = 1'b1;
        state_d      = S_UPDATE;
      end
      S_UPDATE: begin
        if (status_i.done) begin
          if (out_free) begin
            cmd_o.load_out = 1'b1;
            state_d        = S_IDLE;
          end else begin
            state_d = S_HOLD;
          end
        end else begin
          cmd_o.step = 1'b1;
          state_d    = S_SQUARE;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/core/mandelbrot_escape_pixel.sv
// Mandelbrot escape-time pixel engine. Each pixel word (column, row) is mapped
// to c = left_edge + column*column_step + i*(bottom_edge + row*row_step) in
// signed Q4.28 and z = z^2 + c is iterated from zero until |z|^2 >= 4 or the
// iteration limit is reached; the result word gives the count, an in-set flag
// and an RGB color. One pixel is worked on at a time: first the column and row
// products are registered, then c is formed; each iteration registers the
// three squares/products, then updates z.
// A finished word waits in the output register while the next pixel runs.
// Configuration goes through the APB port; the user must write it only while
// the block is idle, and the block itself does not enforce it.
`include "mandelbrot_escape_pixel_defines.svh"

module mandelbrot_escape_pixel import mep_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
  parameter int INDEX_WIDTH = INDEX_WIDTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  mep_pixel_if.sink                 pixel_i,
  mep_result_if.source              result_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_ADDR_WIDTH-1:0] paddr,
  input  logic [APB_DATA_WIDTH-1:0] pwdata,
  output logic [APB_DATA_WIDTH-1:0] prdata,
  output logic                      pready
);

  logic signed [COORD_WIDTH-1:0] left_edge, bottom_edge, column_step, row_step;
  logic [COUNT_WIDTH-1:0]        iteration_limit;
  dp_cmd_t                       dp_cmd;
  dp_status_t                    dp_status;

  mep_regs #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_regs (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel_i            (psel),
    .penable_i         (penable),
    .pwrite_i          (pwrite),
    .paddr_i           (paddr),
    .pwdata_i          (pwdata),
    .prdata_o          (prdata),
    .pready_o          (pready),
    .left_edge_o       (left_edge),
    .bottom_edge_o     (bottom_edge),
    .column_step_o     (column_step),
    .row_step_o        (row_step),
    .iteration_limit_o (iteration_limit)
  );

  mep_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pixel_i.valid),
    .in_ready_o  (pixel_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .status_i    (dp_status),
    .cmd_o       (dp_cmd)
  );

  mep_datapath #(
    .COUNT_WIDTH(COUNT_WIDTH),
    .INDEX_WIDTH(INDEX_WIDTH)
  ) u_datapath (
    .clk_i             (clk_i),
    .cmd_i             (dp_cmd),
    .column_i          (pixel_i.column),
    .row_i             (pixel_i.row),
    .left_edge_i       (left_edge),
    .bottom_edge_i     (bottom_edge),
    .column_step_i     (column_step),
    .row_step_i        (row_step),
    .iteration_limit_i (iteration_limit),
    .status_o          (dp_status),
    .escape_count_o    (result_o.escape_count),
    .in_set_o          (result_o.in_set),
    .red_o             (result_o.red),
    .green_o           (result_o.green),
    .blue_o            (result_o.blue)
  );

  // Once a pixel is taken the engine is busy until its result is registered.
  `MEP_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, pixel_i.valid && pixel_i.ready, !pixel_i.ready, "pixel accepted while previous pixel still in progress")
  // The in-set flag must agree with the count against the programmed limit.
  `MEP_ASSERT_IMP(a_in_set_matches_limit, clk_i, rst_ni, result_o.valid, result_o.in_set == (result_o.escape_count == iteration_limit), "in_set flag disagrees with escape count and limit")
  // A new result word only appears after the engine was busy computing it.
  `MEP_ASSERT_IMP(a_result_from_busy, clk_i, rst_ni, $rose(result_o.valid), $past(!pixel_i.ready), "result word appeared without a pixel in progress")

endmodule
